// ===== rtl/core/line_point_generator_defines.svh =====
// Assertion macros shared by the line point generator RTL.
`ifndef LINE_POINT_GENERATOR_DEFINES_SVH
`define LINE_POINT_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LPG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPG_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define LPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lpg_pkg.sv =====
// Shared types and constants for the line point generator.
`default_nettype none
package lpg_pkg;

  localparam int COORD_W   = 6;
  localparam int COORD_MAX = 64;
  localparam int SIZE_W    = 7;
  localparam int PEN_W     = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PEN_CODE      = 2'd2;

  localparam logic [SIZE_W-1:0] CANVAS_WIDTH_RST  = 7'd64;
  localparam logic [SIZE_W-1:0] CANVAS_HEIGHT_RST = 7'd64;
  localparam logic [PEN_W-1:0]  PEN_CODE_RST      = 8'd42;

  typedef struct packed {
    logic [SIZE_W-1:0] canvas_width;
    logic [SIZE_W-1:0] canvas_height;
    logic [PEN_W-1:0]  pen_code;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpg_regs.sv =====
// APB configuration registers: canvas size and pen code.
`default_nettype none
module lpg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpg_pkg::ADDR_W-1:0] paddr,
  input  logic [lpg_pkg::DATA_W-1:0] pwdata,
  output logic [lpg_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output lpg_pkg::cfg_t              cfg
);
  import lpg_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_width  <= CANVAS_WIDTH_RST;
      cfg.canvas_height <= CANVAS_HEIGHT_RST;
      cfg.pen_code      <= PEN_CODE_RST;
    end else if (wr_en) begin
      case (reg_index)
        REG_CANVAS_WIDTH:  cfg.canvas_width  <= pwdata[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: cfg.canvas_height <= pwdata[SIZE_W-1:0];
        REG_PEN_CODE:      cfg.pen_code      <= pwdata[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CANVAS_WIDTH:  prdata = {{(DATA_W-SIZE_W){1'b0}}, cfg.canvas_width};
      REG_CANVAS_HEIGHT: prdata = {{(DATA_W-SIZE_W){1'b0}}, cfg.canvas_height};
      REG_PEN_CODE:      prdata = {{(DATA_W-PEN_W){1'b0}}, cfg.pen_code};
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpg_ctrl.sv =====
// Segment controller: loads a request, then paces point delivery.
`default_nettype none
`include "line_point_generator_defines.svh"
module lpg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lpg_pkg::status_t   status,
  output lpg_pkg::cmd_t      cmd
);
  import lpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_fire;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_RUN);
  assign out_fire  = out_valid && out_ready;
  assign cmd.load  = in_valid && in_ready;
  assign cmd.step  = out_fire && !status.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_RUN;
      ST_RUN:  if (out_fire && status.last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  `LPG_ASSERT_IMPL(a_no_overlap, clk, rst, out_valid, !in_ready, "busy while idle")
  `LPG_ASSERT_NEXT(a_load_run, clk, rst, cmd.load, out_valid, "no point after load")
  `LPG_ASSERT_NEXT(a_last_idle, clk, rst, out_fire && status.last, in_ready,
                   "not idle after last point")

endmodule
`default_nettype wire

// ===== rtl/core/lpg_dp.sv =====
// Point datapath: endpoint clamping, span setup and the DDA step.
`default_nettype none
`include "line_point_generator_defines.svh"
module lpg_dp #(
  parameter int COORD_MAX = lpg_pkg::COORD_MAX
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lpg_pkg::cmd_t               cmd,
  output lpg_pkg::status_t            status,
  input  lpg_pkg::cfg_t               cfg,
  input  logic [lpg_pkg::COORD_W-1:0] start_x,
  input  logic [lpg_pkg::COORD_W-1:0] start_y,
  input  logic [lpg_pkg::COORD_W-1:0] end_x,
  input  logic [lpg_pkg::COORD_W-1:0] end_y,
  output logic [lpg_pkg::COORD_W-1:0] point_x,
  output logic [lpg_pkg::COORD_W-1:0] point_y,
  output logic                        inside_res,
  output logic [lpg_pkg::PEN_W-1:0]   pen_out
);
  import lpg_pkg::*;

  localparam logic [COORD_W-1:0] CoordLimit = COORD_W'(COORD_MAX - 1);

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    clamp = (v > CoordLimit) ? CoordLimit : v;
  endfunction

  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic               sx_in, sy_in;
  logic [COORD_W-1:0] ax_in, ay_in, n_in;

  // per-segment registers
  logic               sx, sy;
  logic [COORD_W-1:0] ax, ay, n;
  logic [COORD_W-1:0] rx, ry, idx;

  logic [COORD_W:0]   sum_x, sum_y;
  logic               carry_x, carry_y;

  always_comb begin
    x0    = clamp(start_x);
    y0    = clamp(start_y);
    x1    = clamp(end_x);
    y1    = clamp(end_y);
    sx_in = (x1 < x0);
    sy_in = (y1 < y0);
    ax_in = sx_in ? (x0 - x1) : (x1 - x0);
    ay_in = sy_in ? (y0 - y1) : (y1 - y0);
    n_in  = (ax_in > ay_in) ? ax_in : ay_in;
  end

  // remainder stays below n and the span is at most n, so one subtract suffices
  assign sum_x   = {1'b0, rx} + {1'b0, ax};
  assign sum_y   = {1'b0, ry} + {1'b0, ay};
  assign carry_x = (sum_x >= {1'b0, n});
  assign carry_y = (sum_y >= {1'b0, n});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx      <= sx_in;
      sy      <= sy_in;
      ax      <= ax_in;
      ay      <= ay_in;
      n       <= n_in;
      rx      <= '0;
      ry      <= '0;
      idx     <= '0;
      point_x <= x0;
      point_y <= y0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
      if (carry_x) begin
        rx      <= COORD_W'(sum_x - {1'b0, n});
        point_x <= sx ? (point_x - 1'b1) : (point_x + 1'b1);
      end else begin
        rx <= sum_x[COORD_W-1:0];
      end
      if (carry_y) begin
        ry      <= COORD_W'(sum_y - {1'b0, n});
        point_y <= sy ? (point_y - 1'b1) : (point_y + 1'b1);
      end else begin
        ry <= sum_y[COORD_W-1:0];
      end
    end
  end

  assign status.last = (idx == n);
  assign inside_res  = ({1'b0, point_x} < cfg.canvas_width) &&
                       ({1'b0, point_y} < cfg.canvas_height);
  assign pen_out     = cfg.pen_code;

  `LPG_ASSERT_NEXT(a_idx_step, clk, rst, cmd.step, idx == $past(idx) + 1'b1,
                   "step index did not advance")
  `LPG_ASSERT_NEXT(a_rem_bound, clk, rst, cmd.step, (rx < n) && (ry < n),
                   "remainder out of range")

endmodule
`default_nettype wire

// ===== rtl/core/line_point_generator.sv =====
// Top level of the line point generator.
//
//   channel   dir  handshake          payload
//   segment   in   in_valid/in_ready  start_x start_y end_x end_y
//   point     out  out_valid/out_ready point_x point_y inside_res pen_out last_point
//   config    in   APB psel/penable   canvas_width canvas_height pen_code
//
// A segment of n steps yields n+1 points (1 to 64), one per cycle while out_ready
// is high; a load precedes the first point. The points come from the single DDA
// step unit: one point per step.
// A new request is taken only after the last point of the current one is taken.
// A stalled point holds in the output registers. Reset (synchronous) returns
// to idle and restores canvas 64x64 and pen code 42.
`default_nettype none
module line_point_generator #(
  parameter int COORD_MAX = lpg_pkg::COORD_MAX
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpg_pkg::COORD_W-1:0] start_x,
  input  logic [lpg_pkg::COORD_W-1:0] start_y,
  input  logic [lpg_pkg::COORD_W-1:0] end_x,
  input  logic [lpg_pkg::COORD_W-1:0] end_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpg_pkg::COORD_W-1:0] point_x,
  output logic [lpg_pkg::COORD_W-1:0] point_y,
  output logic                        inside_res,
  output logic [lpg_pkg::PEN_W-1:0]   pen_out,
  output logic                        last_point,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpg_pkg::ADDR_W-1:0]  paddr,
  input  logic [lpg_pkg::DATA_W-1:0]  pwdata,
  output logic [lpg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import lpg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign last_point = status.last;

  lpg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpg_dp #(
    .COORD_MAX (COORD_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .point_x    (point_x),
    .point_y    (point_y),
    .inside_res (inside_res),
    .pen_out    (pen_out)
  );

endmodule
`default_nettype wire
